// ===== hdl/ssc_pkg.sv =====
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared types and constants for the supersampled shape coverage core.
// ----------------------------------------------------------------------------
package ssc_pkg;

    localparam int CFG_W   = 11;
    localparam int IDX_W   = 3;
    localparam int COORD_W = 11;
    localparam int PHASE_W = 12;
    localparam int SQ_W    = 25;
    localparam int SUB_N   = 16;
    localparam int COL_W   = 4;
    localparam int CNT_W   = 5;
    localparam int ACC_W   = 9;

    localparam logic [2:0] SHP_CROSS  = 3'd0;
    localparam logic [2:0] SHP_LINE   = 3'd1;
    localparam logic [2:0] SHP_CORNER = 3'd2;
    localparam logic [2:0] SHP_TEE    = 3'd3;
    localparam logic [2:0] SHP_STUB   = 3'd4;
    localparam logic [2:0] SHP_HENTRY = 3'd5;
    localparam logic [2:0] SHP_HWIRE  = 3'd6;

    localparam logic [IDX_W-1:0] REG_LINE_HW   = 3'd0;
    localparam logic [IDX_W-1:0] REG_ROUND_R   = 3'd1;
    localparam logic [IDX_W-1:0] REG_DOT_R     = 3'd2;
    localparam logic [IDX_W-1:0] REG_PADDING   = 3'd3;
    localparam logic [IDX_W-1:0] REG_SUBDOT_R  = 3'd4;
    localparam logic [IDX_W-1:0] REG_SUBLINE_W = 3'd5;
    localparam logic [IDX_W-1:0] REG_HATCH_PER = 3'd6;
    localparam logic [IDX_W-1:0] REG_HATCH_DTY = 3'd7;

    typedef struct packed {
        logic [CFG_W-1:0]        lw;
        logic signed [CFG_W:0]   c;
        logic [CFG_W:0]          lwp;
        logic [SQ_W-1:0]         d2;
        logic [SQ_W-1:0]         dp2;
        logic [SQ_W-1:0]         rr2;
        logic [SQ_W-1:0]         r02;
        logic [SQ_W-1:0]         b2;
        logic [CFG_W-1:0]        sw;
        logic [CFG_W-1:0]        per;
        logic [CFG_W-1:0]        duty;
    } cfg_t;

    typedef struct packed {
        logic                      vld;
        logic                      first;
        logic                      last;
        logic [2:0]                shape;
        logic signed [COORD_W-1:0] u;
        logic signed [COORD_W-1:0] v;
        logic [SQ_W-1:0]           u2;
        logic [SQ_W-1:0]           a2;
        logic [PHASE_W-1:0]        phase;
        logic [CNT_W-1:0]          cnt;
    } tok_t;

endpackage

// ===== hdl/ssc_cfg.sv =====
// ----------------------------------------------------------------------------
// ssc_cfg
// Style register file and derived squared limits.
// ----------------------------------------------------------------------------
module ssc_cfg
    import ssc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    output cfg_t              cfg
);

    logic [CFG_W-1:0] lw_reg, rr_reg, dr_reg, pd_reg, br_reg, sw_reg, per_reg, duty_reg;
    cfg_t             cfg_reg, cfg_next;

    logic signed [CFG_W+1:0] r0;
    logic signed [2*CFG_W+3:0] r0sq;
    logic [CFG_W:0]          dp;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lw_reg   <= CFG_W'(51);
            rr_reg   <= CFG_W'(358);
            dr_reg   <= CFG_W'(256);
            pd_reg   <= CFG_W'(51);
            br_reg   <= CFG_W'(512);
            sw_reg   <= CFG_W'(256);
            per_reg  <= CFG_W'(128);
            duty_reg <= CFG_W'(84);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_LINE_HW:   lw_reg   <= cfg_data;
                REG_ROUND_R:   rr_reg   <= cfg_data;
                REG_DOT_R:     dr_reg   <= cfg_data;
                REG_PADDING:   pd_reg   <= cfg_data;
                REG_SUBDOT_R:  br_reg   <= cfg_data;
                REG_SUBLINE_W: sw_reg   <= cfg_data;
                REG_HATCH_PER: per_reg  <= cfg_data;
                REG_HATCH_DTY: duty_reg <= cfg_data;
                default:       lw_reg   <= lw_reg;
            endcase
        end
    end

    always_comb
    begin
        r0   = $signed({2'b00, rr_reg}) - $signed({1'b0, lw_reg, 1'b0});
        r0sq = r0 * r0;
        dp   = {1'b0, dr_reg} + {1'b0, pd_reg};
        cfg_next.lw   = lw_reg;
        cfg_next.c    = $signed({1'b0, rr_reg}) - $signed({1'b0, lw_reg});
        cfg_next.lwp  = {1'b0, lw_reg} + {1'b0, pd_reg};
        cfg_next.d2   = SQ_W'(dr_reg * dr_reg);
        cfg_next.dp2  = SQ_W'(dp * dp);
        cfg_next.rr2  = SQ_W'(rr_reg * rr_reg);
        cfg_next.r02  = SQ_W'($unsigned(r0sq));
        cfg_next.b2   = SQ_W'(br_reg * br_reg);
        cfg_next.sw   = sw_reg;
        cfg_next.per  = per_reg;
        cfg_next.duty = duty_reg;
    end

    always_ff @(posedge clk)
    begin
        cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/ssc_src.sv =====
// ----------------------------------------------------------------------------
// ssc_src
// Takes a pixel word, reduces its hatch phase modulo the period bit by bit,
// then issues one column word per cycle into the cell row while en is high.
// ----------------------------------------------------------------------------
module ssc_src
    import ssc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  cfg_t         cfg,
    input  logic         item_valid,
    output logic         item_stall,
    input  logic [2:0]   shape,
    input  logic [6:0]   pixel_x,
    input  logic [6:0]   pixel_y,
    output tok_t         tout
);

    logic                      dv_vld_reg, dv_vld_next;
    logic [3:0]                dv_cnt_reg, dv_cnt_next;
    logic [PHASE_W-1:0]        dv_rem_reg, dv_rem_next;
    logic [PHASE_W-1:0]        dv_num_reg, dv_num_next;
    logic [2:0]                dv_shape_reg, dv_shape_next;
    logic signed [COORD_W-1:0] dv_u_reg, dv_u_next;
    logic signed [COORD_W-1:0] dv_v_reg, dv_v_next;

    logic                      is_vld_reg, is_vld_next;
    logic [COL_W-1:0]          is_col_reg, is_col_next;
    logic [2:0]                is_shape_reg, is_shape_next;
    logic signed [COORD_W-1:0] is_u_reg, is_u_next;
    logic signed [COORD_W-1:0] is_v_reg, is_v_next;
    logic [PHASE_W-1:0]        is_ph_reg, is_ph_next;

    tok_t                      tok_reg, tok_next;

    logic                      dv_done, is_last, xfer, accept;
    logic [PHASE_W-1:0]        trial, ph_inc;
    logic signed [CFG_W+1:0]   amin, a;
    logic signed [2*CFG_W+3:0] a_sq;
    logic signed [2*COORD_W-1:0] u_sq;

    always_comb
    begin
        dv_done    = dv_vld_reg && (dv_cnt_reg == '0);
        is_last    = is_vld_reg && (is_col_reg == COL_W'(SUB_N - 1));
        xfer       = en && dv_done && (!is_vld_reg || is_last);
        item_stall = !(en && (!dv_vld_reg || xfer));
        accept     = item_valid && !item_stall;

        dv_vld_next   = dv_vld_reg;
        dv_cnt_next   = dv_cnt_reg;
        dv_rem_next   = dv_rem_reg;
        dv_num_next   = dv_num_reg;
        dv_shape_next = dv_shape_reg;
        dv_u_next     = dv_u_reg;
        dv_v_next     = dv_v_reg;
        trial         = {dv_rem_reg[PHASE_W-2:0], dv_num_reg[PHASE_W-1]};

        if (accept)
        begin
            dv_vld_next   = 1'b1;
            dv_cnt_next   = 4'(PHASE_W);
            dv_rem_next   = '0;
            dv_num_next   = PHASE_W'({1'b0, pixel_x} + {1'b0, pixel_y}) << 4;
            dv_shape_next = shape;
            dv_u_next     = $signed(COORD_W'({pixel_x, 4'b0000}) - COORD_W'(1024));
            dv_v_next     = $signed(COORD_W'({pixel_y, 4'b0000}) - COORD_W'(1024));
        end
        else if (xfer)
        begin
            dv_vld_next = 1'b0;
        end
        else if (en && dv_vld_reg && !dv_done)
        begin
            dv_cnt_next = dv_cnt_reg - 4'd1;
            dv_num_next = dv_num_reg << 1;
            if (cfg.per != '0 && trial >= {1'b0, cfg.per})
                dv_rem_next = trial - {1'b0, cfg.per};
            else
                dv_rem_next = trial;
        end

        ph_inc = is_ph_reg + PHASE_W'(1);
        if (cfg.per != '0 && ph_inc == {1'b0, cfg.per})
            ph_inc = '0;

        is_vld_next   = is_vld_reg;
        is_col_next   = is_col_reg;
        is_shape_next = is_shape_reg;
        is_u_next     = is_u_reg;
        is_v_next     = is_v_reg;
        is_ph_next    = is_ph_reg;
        if (xfer)
        begin
            is_vld_next   = 1'b1;
            is_col_next   = '0;
            is_shape_next = dv_shape_reg;
            is_u_next     = dv_u_reg;
            is_v_next     = dv_v_reg;
            is_ph_next    = dv_rem_reg;
        end
        else if (en && is_vld_reg)
        begin
            is_vld_next = !is_last;
            is_col_next = is_col_reg + COL_W'(1);
            is_u_next   = is_u_reg + COORD_W'(1);
            is_ph_next  = ph_inc;
        end

        amin = (is_u_reg > cfg.c) ? {cfg.c[CFG_W], cfg.c}
                                  : {{2{is_u_reg[COORD_W-1]}}, is_u_reg};
        a    = amin - {cfg.c[CFG_W], cfg.c};
        a_sq = a * a;
        u_sq = is_u_reg * is_u_reg;

        tok_next.vld   = is_vld_reg;
        tok_next.first = (is_col_reg == '0);
        tok_next.last  = is_last;
        tok_next.shape = is_shape_reg;
        tok_next.u     = is_u_reg;
        tok_next.v     = is_v_reg;
        tok_next.u2    = SQ_W'($unsigned(u_sq));
        tok_next.a2    = SQ_W'($unsigned(a_sq));
        tok_next.phase = is_ph_reg;
        tok_next.cnt   = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_vld_reg <= 1'b0;
            dv_cnt_reg <= '0;
            is_vld_reg <= 1'b0;
            is_col_reg <= '0;
            tok_reg    <= '0;
        end
        else
        begin
            dv_vld_reg <= dv_vld_next;
            dv_cnt_reg <= dv_cnt_next;
            is_vld_reg <= is_vld_next;
            is_col_reg <= is_col_next;
            if (en)
                tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dv_rem_reg   <= dv_rem_next;
        dv_num_reg   <= dv_num_next;
        dv_shape_reg <= dv_shape_next;
        dv_u_reg     <= dv_u_next;
        dv_v_reg     <= dv_v_next;
        is_shape_reg <= is_shape_next;
        is_u_reg     <= is_u_next;
        is_v_reg     <= is_v_next;
        is_ph_reg    <= is_ph_next;
    end

    assign tout = tok_reg;

endmodule

// ===== hdl/ssc_cell.sv =====
// ----------------------------------------------------------------------------
// ssc_cell
// One subsample row: tests the passing column word against the shape,
// adds its hit, and hands the word on with the next row and phase.
// ----------------------------------------------------------------------------
module ssc_cell
    import ssc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  cfg_t cfg,
    input  tok_t tin,
    output tok_t tout
);

    tok_t                        tok_reg, tok_next;
    logic signed [COORD_W-1:0]   u, v;
    logic signed [2*COORD_W-1:0] v_sq;
    logic signed [CFG_W+1:0]     bmin, b;
    logic signed [2*CFG_W+3:0]   b_sq;
    logic [SQ_W-1:0]             v2, b2, duv, dab;
    logic [COORD_W-1:0]          absu, absv;
    logic                        st_u, st_v, dot, hatch, vpos, vneg, hit;
    logic                        outer, clear;
    logic [PHASE_W-1:0]          ph_inc;

    always_comb
    begin
        u     = tin.u;
        v     = tin.v;
        v_sq  = v * v;
        v2    = SQ_W'($unsigned(v_sq));
        bmin  = (v > cfg.c) ? {cfg.c[CFG_W], cfg.c} : {{2{v[COORD_W-1]}}, v};
        b     = bmin - {cfg.c[CFG_W], cfg.c};
        b_sq  = b * b;
        b2    = SQ_W'($unsigned(b_sq));
        duv   = tin.u2 + v2;
        dab   = tin.a2 + b2;
        absu  = u[COORD_W-1] ? COORD_W'(-u) : COORD_W'(u);
        absv  = v[COORD_W-1] ? COORD_W'(-v) : COORD_W'(v);
        st_u  = absu < cfg.lw;
        st_v  = absv < cfg.lw;
        dot   = duv < cfg.d2;
        vneg  = v[COORD_W-1];
        vpos  = !vneg && (v != '0);
        hatch = tin.phase < {1'b0, cfg.duty};
        outer = (duv < cfg.b2) || ((absu < cfg.sw) && vneg);
        clear = (({1'b0, absu} < cfg.lwp) && vpos) || (duv < cfg.dp2);

        case (tin.shape)
            SHP_CROSS:  hit = st_u || st_v || dot;
            SHP_LINE:   hit = st_u;
            SHP_CORNER: hit = (cfg.r02 < dab) && (dab < cfg.rr2);
            SHP_TEE:    hit = (st_u && vpos) || st_v || dot;
            SHP_STUB:   hit = (st_u && vpos) || dot;
            SHP_HENTRY: hit = outer && !clear && hatch;
            SHP_HWIRE:  hit = (absu < cfg.sw) && hatch;
            default:    hit = 1'b0;
        endcase

        ph_inc = tin.phase + PHASE_W'(1);
        if (cfg.per != '0 && ph_inc == {1'b0, cfg.per})
            ph_inc = '0;

        tok_next       = tin;
        tok_next.v     = v + COORD_W'(1);
        tok_next.phase = ph_inc;
        tok_next.cnt   = tin.cnt + CNT_W'(hit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_reg <= '0;
        else if (en)
            tok_reg <= tok_next;
    end

    assign tout = tok_reg;

endmodule

// ===== hdl/supersampled_shape_coverage_core.sv =====
// ----------------------------------------------------------------------------
// supersampled_shape_coverage_core
// Grey level of one tile pixel from a 16x16 subsample coverage test.
//
//   channel | handshake                 | word
//   item    | item_valid / item_stall   | shape, pixel_x, pixel_y
//   result  | result_valid / result_stall | coverage
//   cfg     | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// The source issues one column word per cycle while the row is not frozen, and
// a row of 16 cells, one per subsample row, tests it on its way down.
// The phase remainder of a new pixel is formed bit by bit while the source
// still issues the previous pixel's column words.
// Reset returns the style registers to defaults.
// The row freezes only when a finished word meets a full, stalled output.
// ----------------------------------------------------------------------------
module supersampled_shape_coverage_core
    import ssc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  logic [2:0]       shape,
    input  logic [6:0]       pixel_x,
    input  logic [6:0]       pixel_y,
    output logic             result_valid,
    input  logic             result_stall,
    output logic [7:0]       coverage,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    cfg_t             cfg;
    tok_t             chain [0:SUB_N];
    tok_t             tail;
    logic             en, done;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic             out_vld_reg, out_vld_next;
    logic [7:0]       cov_reg, cov_next;
    logic [ACC_W+7:0] scaled;

    ssc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ssc_src u_src (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .shape      (shape),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .tout       (chain[0])
    );

    for (genvar k = 0; k < SUB_N; k++)
    begin : g_cell
        ssc_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .cfg   (cfg),
            .tin   (chain[k]),
            .tout  (chain[k+1])
        );
    end

    assign tail = chain[SUB_N];

    always_comb
    begin
        done     = tail.vld && tail.last;
        en       = !(out_vld_reg && result_stall && done);
        acc_next = (tail.first ? ACC_W'(0) : acc_reg) + ACC_W'(tail.cnt);
        scaled   = {acc_next, 8'b0} - (ACC_W+8)'(acc_next);
        cov_next = cov_reg;
        out_vld_next = out_vld_reg;
        if (en && done)
        begin
            out_vld_next = 1'b1;
            cov_next     = scaled[15:8];
        end
        else if (!result_stall)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else
            out_vld_reg <= out_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (en && tail.vld)
            acc_reg <= acc_next;
        cov_reg <= cov_next;
    end

    assign result_valid = out_vld_reg;
    assign coverage     = cov_reg;

endmodule
